[rtl/assert_macros.svh]
// Assertion macros used by the datapath module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SOA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab allocator assertion failed");

// next-cycle implication
`define SOA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab allocator assertion failed");

`endif

[rtl/soa_pkg.sv]
// Types, codes and constants of the slab object allocator
`default_nettype none
package soa_pkg;

  localparam int MAX_OBJECTS = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int SIZE_W      = 20;
  localparam int BASE_W      = 32;
  localparam int ADDR_W      = 33;
  localparam int PROD_W      = SIZE_W + IDX_W;
  localparam int WORD_W      = CNT_W + 1;

  localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(MAX_OBJECTS);
  localparam logic [CNT_W-1:0] LINK_END = CNT_W'(MAX_OBJECTS + 1);

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_RUN   = 2'd1,
    K_FREE  = 2'd2,
    K_RESET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_EXHAUSTED   = 3'd1,
    STAT_WRONG_MODE  = 3'd2,
    STAT_DOUBLE_FREE = 3'd3,
    STAT_RANGE       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_MODE      = 2'd0,
    CFG_POOL_SIZE = 2'd1,
    CFG_OBJ_SIZE  = 2'd2,
    CFG_BASE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_reset;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/soa_ctrl.sv]
// Controller state machine of the slab object allocator
`default_nettype none
module soa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire soa_pkg::sts_t sts,
  output soa_pkg::cmd_t      cmd
);

  soa_pkg::state_t state_r, state_nxt;
  logic            from_item_r, from_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= soa_pkg::S_CLEAR;
      from_item_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_item_r <= from_item_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      soa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.in_reset ? soa_pkg::S_CLEAR : soa_pkg::S_EXEC;
        end
      end
      soa_pkg::S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = from_item_r ? soa_pkg::S_EXEC : soa_pkg::S_IDLE;
        end
      end
      soa_pkg::S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = soa_pkg::S_IDLE;
        end
      end
      default: state_nxt = soa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      soa_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.accept    = in_tvalid;
        cmd.clr_start = in_tvalid & sts.in_reset;
      end
      soa_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      soa_pkg::S_EXEC:  cmd.commit   = sts.out_free;
      default: ;
    endcase
    from_item_nxt = from_item_r | cmd.clr_start;
  end

endmodule
`default_nettype wire

[rtl/soa_dp.sv]
// Datapath of the slab object allocator: registers, link memory, address math
`default_nettype none
`include "assert_macros.svh"
module soa_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire soa_pkg::cmd_t cmd,
  output soa_pkg::sts_t      sts,
  input  wire logic [1:0]    in_tuser,
  input  wire logic [23:0]   in_tdata,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_wdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [2:0]         out_tuser,
  output logic [55:0]        out_tdata
);

  localparam int IW = soa_pkg::IDX_W;
  localparam int CW = soa_pkg::CNT_W;

  // config
  logic                       mode_r;
  logic [CW-1:0]              pool_size_r;
  logic [soa_pkg::SIZE_W-1:0] obj_size_r;
  logic [soa_pkg::BASE_W-1:0] base_r;

  // allocator state
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] use_r, use_nxt;
  logic [CW-1:0] clr_n_r;
  logic [IW-1:0] clr_cnt_r;

  // link memory: {taken, next link}
  logic [soa_pkg::WORD_W-1:0] mem [soa_pkg::MAX_OBJECTS];
  logic [soa_pkg::WORD_W-1:0] rdata_r;
  logic [soa_pkg::WORD_W-1:0] mem_wdata;
  logic [IW-1:0]              mem_waddr;
  logic                       mem_we;

  // captured item
  soa_pkg::kind_t              kind_r;
  logic [CW-1:0]               run_r;
  logic [IW-1:0]               obj_r;
  logic [soa_pkg::PROD_W-1:0]  prod_r;
  logic [IW-1:0]               rd_addr;

  // result
  logic                        out_valid_r;
  soa_pkg::status_t            out_status_r;
  logic [IW-1:0]               out_index_r;
  logic [soa_pkg::ADDR_W-1:0]  out_addr_r;
  logic [CW-1:0]               out_use_r;

  // execute logic
  logic [CW-1:0]     pool_eff;
  logic [CW-1:0]     run_eff;
  logic [CW-1:0]     bump_n;
  logic [CW:0]       bump_sum;
  soa_pkg::status_t  stat;
  logic              report;
  logic [IW-1:0]     idx;
  logic              x_we;
  logic [IW-1:0]     x_waddr;
  logic [soa_pkg::WORD_W-1:0] x_wdata;
  logic [CW-1:0]     clr_link;

  assign pool_eff = (pool_size_r > soa_pkg::POOL_MAX) ? soa_pkg::POOL_MAX : pool_size_r;
  assign run_eff  = (run_r == '0) ? CW'(1) : run_r;
  assign rd_addr  = (soa_pkg::kind_t'(in_tuser) == soa_pkg::K_FREE) ? in_tdata[20:11]
                                                                     : head_r[IW-1:0];

  assign sts.in_reset = (soa_pkg::kind_t'(in_tuser) == soa_pkg::K_RESET);
  assign sts.clr_last = (clr_cnt_r == IW'(soa_pkg::MAX_OBJECTS - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      pool_size_r <= soa_pkg::POOL_MAX;
      obj_size_r  <= soa_pkg::SIZE_W'(64);
      base_r      <= '0;
    end else if (cfg_we) begin
      unique case (soa_pkg::cfg_idx_t'(cfg_index))
        soa_pkg::CFG_MODE:      mode_r      <= cfg_wdata[0];
        soa_pkg::CFG_POOL_SIZE: pool_size_r <= cfg_wdata[CW-1:0];
        soa_pkg::CFG_OBJ_SIZE:  obj_size_r  <= cfg_wdata[soa_pkg::SIZE_W-1:0];
        soa_pkg::CFG_BASE:      base_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture, link read and index scaling
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= soa_pkg::kind_t'(in_tuser);
      run_r   <= in_tdata[10:0];
      obj_r   <= in_tdata[20:11];
      rdata_r <= mem[rd_addr];
      prod_r  <= {{IW{1'b0}}, obj_size_r} * {{soa_pkg::SIZE_W{1'b0}}, rd_addr};
    end
  end

  always_comb begin
    stat     = soa_pkg::STAT_OK;
    report   = 1'b0;
    idx      = '0;
    head_nxt = head_r;
    use_nxt  = use_r;
    x_we     = 1'b0;
    x_waddr  = head_r[IW-1:0];
    x_wdata  = rdata_r;
    bump_n   = (kind_r == soa_pkg::K_RUN) ? run_eff : CW'(1);
    bump_sum = {1'b0, use_r} + {1'b0, bump_n};
    case (kind_r) inside
      soa_pkg::K_RESET: ;
      soa_pkg::K_FREE: begin
        if (!mode_r) begin
          stat = soa_pkg::STAT_WRONG_MODE;
        end else if ({1'b0, obj_r} >= pool_eff) begin
          stat = soa_pkg::STAT_RANGE;
        end else if (!rdata_r[CW]) begin
          stat = soa_pkg::STAT_DOUBLE_FREE;
        end else begin
          x_we     = 1'b1;
          x_waddr  = obj_r;
          x_wdata  = {1'b0, head_r};
          head_nxt = {1'b0, obj_r};
          use_nxt  = (use_r != '0) ? use_r - CW'(1) : use_r;
          report   = 1'b1;
          idx      = obj_r;
        end
      end
      soa_pkg::K_ALLOC, soa_pkg::K_RUN: begin
        if (mode_r) begin
          if (kind_r == soa_pkg::K_RUN) begin
            stat = soa_pkg::STAT_WRONG_MODE;
          end else if (use_r >= pool_eff || head_r >= pool_eff) begin
            stat = soa_pkg::STAT_EXHAUSTED;
          end else begin
            x_we     = 1'b1;
            x_wdata  = {1'b1, rdata_r[CW-1:0]};
            head_nxt = rdata_r[CW-1:0];
            use_nxt  = use_r + CW'(1);
            report   = 1'b1;
            idx      = head_r[IW-1:0];
          end
        end else begin
          if (bump_sum > {1'b0, pool_eff} || head_r >= pool_eff) begin
            stat = soa_pkg::STAT_EXHAUSTED;
          end else begin
            head_nxt = head_r + bump_n;
            use_nxt  = bump_sum[CW-1:0];
            report   = 1'b1;
            idx      = head_r[IW-1:0];
          end
        end
      end
    endcase
  end

  // rebuild value of one link during the clearing pass, and the link memory write select
  always_comb begin
    if (clr_n_r != '0 && {1'b0, clr_cnt_r} == clr_n_r - CW'(1)) begin
      clr_link = soa_pkg::LINK_END;
    end else begin
      clr_link = {1'b0, clr_cnt_r} + CW'(1);
    end
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = {1'b0, clr_link};
    end else begin
      mem_we    = cmd.commit & x_we;
      mem_waddr = x_waddr;
      mem_wdata = x_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      use_r     <= '0;
      clr_n_r   <= soa_pkg::POOL_MAX;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clr_start) begin
        head_r    <= '0;
        use_r     <= '0;
        clr_n_r   <= pool_eff;
        clr_cnt_r <= '0;
      end else begin
        if (cmd.commit) begin
          head_r <= head_nxt;
          use_r  <= use_nxt;
        end
        if (cmd.clr_step) begin
          clr_cnt_r <= clr_cnt_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= stat;
      out_index_r  <= idx;
      out_addr_r   <= report ? ({1'b0, base_r} + {3'b000, prod_r}) : '0;
      out_use_r    <= use_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_use_r, out_addr_r, out_index_r};

  `SOA_ASSERT_IMP(a_commit_out_free, cmd.commit, sts.out_free)
  `SOA_ASSERT_NXT(a_commit_valid, cmd.commit, out_valid_r)
  `SOA_ASSERT_IMP(a_one_writer, cmd.clr_step, !cmd.commit && !cmd.accept)
  `SOA_ASSERT_IMP(a_use_bound, 1'b1, use_r <= soa_pkg::POOL_MAX)

endmodule
`default_nettype wire

[rtl/slab_object_allocator.sv]
// Top level of the slab object allocator
//
//  channel  dir  handshake          payload
//  in_      in   tvalid/tready      tuser: kind; tdata: run_length, object_index
//  out_     out  tvalid/tready      tuser: status; tdata: index, address, in use
//  cfg_     in   we (no wait)       index, wdata
//
// An item is handled in order: accept with the link-memory read and the index
// multiply, then execute with the link write-back and the result register load.
// Pool reset sweeps all 1024 link entries, one per cycle.
// After rst_n the same sweep runs before the first item is taken.
// Execute holds while the result register is full and not being drained.
`default_nettype none
module slab_object_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  input  wire logic [23:0] in_tdata,   // run_length[10:0], object_index[20:11], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [2:0]       out_tuser,  // status[2:0]
  output logic [55:0]      out_tdata,  // granted_index[9:0], granted_address[42:10],
                                       // objects_in_use[53:43], zero pad
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  soa_pkg::cmd_t cmd;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  soa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[sim/slab_object_allocator_checker.sv]
// Grant checker for the slab object allocator: mirrors pool state, predicts and compares results
`default_nettype none
module slab_object_allocator_checker
  import soa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  input  wire logic [23:0] in_tdata,   // run_length[10:0], object_index[20:11], zero pad
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [2:0]  out_tuser,  // status[2:0]
  input  wire logic [55:0] out_tdata,  // granted_index[9:0], granted_address[42:10],
                                       // objects_in_use[53:43], zero pad
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output int               pending_grants,
  output int               mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  index;
    logic [32:0] address;
    logic [10:0] in_use;
  } grant_t;

  logic        mode_q;
  logic [10:0] pool_q;
  logic [19:0] obj_size_q;
  logic [31:0] base_q;

  int unsigned link_mem [MAX_OBJECTS];
  bit          taken_mem [MAX_OBJECTS];
  int unsigned head_q;
  int unsigned in_use_q;
  grant_t      grants_due [$];

  function automatic int unsigned live_pool();
    return (pool_q > POOL_MAX) ? MAX_OBJECTS : int'(pool_q);
  endfunction

  function automatic void rebuild_free_list();
    int unsigned n;
    int          i;
    n = live_pool();
    for (i = 0; i < MAX_OBJECTS; i++) begin
      link_mem[i]  = i + 1;
      taken_mem[i] = 1'b0;
    end
    if (n > 0) link_mem[n-1] = LINK_END;
    head_q   = 0;
    in_use_q = 0;
  endfunction

  function automatic grant_t serve_request(kind_t kind, logic [10:0] run_field,
                                           logic [9:0] obj);
    grant_t      g;
    int unsigned pool, run, n, idx;
    logic [63:0] addr;
    bit          granted;
    pool    = live_pool();
    run     = (run_field == 0) ? 1 : run_field;
    g       = '0;
    idx     = 0;
    granted = 1'b0;
    g.status = STAT_OK;
    case (kind)
      K_RESET: rebuild_free_list();
      K_FREE: begin
        if (!mode_q) g.status = STAT_WRONG_MODE;
        else if (obj >= pool) g.status = STAT_RANGE;
        else if (!taken_mem[obj]) g.status = STAT_DOUBLE_FREE;
        else begin
          link_mem[obj]  = head_q;
          taken_mem[obj] = 1'b0;
          head_q         = obj;
          if (in_use_q > 0) in_use_q--;
          idx     = obj;
          granted = 1'b1;
        end
      end
      default: begin
        if (mode_q) begin
          if (kind == K_RUN) g.status = STAT_WRONG_MODE;
          else if (in_use_q >= pool || head_q >= pool) g.status = STAT_EXHAUSTED;
          else begin
            idx            = head_q;
            taken_mem[idx] = 1'b1;
            head_q         = link_mem[idx];
            in_use_q++;
            granted = 1'b1;
          end
        end else begin
          n = (kind == K_RUN) ? run : 1;
          if (in_use_q + n > pool || head_q >= pool) g.status = STAT_EXHAUSTED;
          else begin
            idx      = head_q;
            head_q   = head_q + n;
            in_use_q = in_use_q + n;
            granted  = 1'b1;
          end
        end
      end
    endcase
    addr = 64'(base_q) + 64'(obj_size_q) * 64'(idx[9:0]);
    if (granted) begin
      g.index   = idx[9:0];
      g.address = addr[32:0];
    end
    g.in_use = in_use_q[10:0];
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want, got;
    if (!rst_n) begin
      mode_q     = 1'b1;
      pool_q     = POOL_MAX;
      obj_size_q = 20'd64;
      base_q     = '0;
      rebuild_free_list();
      grants_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODE:      mode_q     = cfg_wdata[0];
          CFG_POOL_SIZE: pool_q     = cfg_wdata[10:0];
          CFG_OBJ_SIZE:  obj_size_q = cfg_wdata[19:0];
          CFG_BASE:      base_q     = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.status  = out_tuser;
        got.index   = out_tdata[9:0];
        got.address = out_tdata[42:10];
        got.in_use  = out_tdata[53:43];
        if (grants_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: status %0d index %0d address 0x%0h in_use %0d",
                     got.status, got.index, got.address, got.in_use);
          mismatch_count++;
        end else begin
          want = grants_due.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.address !== want.address || got.in_use !== want.in_use) begin
            if (mismatch_count < 10) begin
              $write("grant mismatch (exp/got): status %0d/%0d index %0d/%0d ",
                     want.status, got.status, want.index, got.index);
              $display("address 0x%0h/0x%0h in_use %0d/%0d",
                       want.address, got.address, want.in_use, got.in_use);
            end
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        grants_due.push_back(serve_request(kind_t'(in_tuser), in_tdata[10:0],
                                           in_tdata[20:11]));
    end
    pending_grants = grants_due.size();
  end

endmodule
`default_nettype wire

[sim/slab_object_allocator_tb.sv]
// Testbench top for the slab object allocator: clock, reset, request stimulus and verdict
`default_nettype none
module slab_object_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import soa_pkg::*;

  localparam int QUIET_LIMIT = 8000;
  localparam int TAIL_CYCLES = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;
  logic [55:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  int pending_grants;
  int mismatch_count;
  int quiet_cycles = 0;
  int ready_hold   = 0;
  int unsigned ready_roll;
  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;

  slab_object_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  slab_object_allocator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tuser      (out_tuser),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pending_grants (pending_grants),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready = 1'b0;
      ready_hold--;
    end else begin
      out_tready = 1'b1;
      if (rx_stalls) begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 10) ready_hold = $urandom_range(1, 3);
        else if (ready_roll < 12) ready_hold = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT - 1) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!tx_gaps || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(kind_t kind, logic [10:0] run, logic [9:0] obj);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {3'b000, obj, run};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_grants != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic configure(logic mode, logic [10:0] pool, logic [19:0] osize,
                           logic [31:0] base);
    wait_drained();
    write_reg(CFG_MODE, {31'($urandom), mode});
    write_reg(CFG_POOL_SIZE, {21'($urandom), pool});
    write_reg(CFG_OBJ_SIZE, {12'($urandom), osize});
    write_reg(CFG_BASE, base);
  endtask

  task automatic run_phase(logic mode, logic [10:0] pool, logic [19:0] osize,
                           logic [31:0] base, bit clear_first, int items,
                           bit gaps, bit stalls);
    int unsigned roll, live, hint;
    int          n;
    kind_t       kind;
    logic [10:0] run;
    logic [9:0]  obj;
    configure(mode, pool, osize, base);
    tx_gaps   = gaps;
    rx_stalls = stalls;
    live = (pool > 11'd1024) ? 1024 : pool;
    hint = live;
    if (clear_first) begin
      send_item(K_RESET, 11'($urandom), 10'($urandom));
      hint = 0;
    end
    for (n = 0; n < items; n++) begin
      if ($urandom_range(0, 49) == 0) wait_drained();
      roll = $urandom_range(0, 99);
      run  = 11'($urandom);
      obj  = 10'($urandom);
      if (mode) begin
        if (roll < 4) kind = K_RESET;
        else if (roll < 52) kind = K_ALLOC;
        else if (roll < 92) kind = K_FREE;
        else kind = K_RUN;
      end else begin
        if (roll < 9) kind = K_RESET;
        else if (roll < 40) kind = K_ALLOC;
        else if (roll < 92) kind = K_RUN;
        else kind = K_FREE;
      end
      if (kind == K_RUN) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) run = 11'($urandom_range(0, 8));
        else if (roll >= 90) begin
          case ($urandom_range(0, 4))
            0: run = 11'd0;
            1: run = 11'd1;
            2: run = 11'd1023;
            3: run = 11'd1024;
            default: run = 11'h7FF;
          endcase
        end
      end
      if (kind == K_FREE && hint > 0 && $urandom_range(0, 99) < 85)
        obj = 10'($urandom_range(0, hint - 1));
      if (kind == K_RESET) hint = 0;
      else if (kind == K_ALLOC && mode && hint < live) hint++;
      send_item(kind, run, obj);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // power-on free list, default registers
    send_item(K_ALLOC, 11'h7FF, 10'h3FF);
    send_item(K_FREE, 11'h000, 10'd0);

    // linked mode, four objects, widest address
    configure(1'b1, 11'd4, 20'hFFFFF, 32'hFFFF_FFFF);
    send_item(K_RESET, 11'h7FF, 10'h3FF);
    repeat (5) send_item(K_ALLOC, 11'h000, 10'h000);
    send_item(K_RUN, 11'h7FF, 10'h000);
    send_item(K_FREE, 11'h000, 10'd2);
    send_item(K_FREE, 11'h000, 10'd2);
    send_item(K_FREE, 11'h000, 10'd4);
    send_item(K_FREE, 11'h7FF, 10'h3FF);
    send_item(K_ALLOC, 11'h000, 10'h000);
    send_item(K_FREE, 11'h000, 10'd3);
    send_item(K_FREE, 11'h000, 10'd0);

    // bump mode, six objects
    configure(1'b0, 11'd6, 20'd1, 32'd0);
    send_item(K_FREE, 11'h000, 10'd1);
    send_item(K_RESET, 11'h000, 10'h000);
    send_item(K_RUN, 11'd0, 10'h3FF);
    send_item(K_RUN, 11'd3, 10'h000);
    repeat (3) send_item(K_ALLOC, 11'h000, 10'h000);
    send_item(K_RUN, 11'h7FF, 10'h000);

    run_phase(1'b1, 11'd16, 20'($urandom_range(1, 20'hFFFFF)), $urandom, 1'b1, 80,
              1'b1, 1'b1);
    run_phase(1'b0, 11'd32, 20'd1, 32'd0, 1'b1, 80, 1'b0, 1'b1);
    run_phase(1'b1, 11'd1024, 20'hFFFFF, 32'hFFFF_FFFF, 1'b0, 80, 1'b1, 1'b0);
    run_phase(1'b0, 11'h7FF, 20'($urandom_range(1, 20'hFFFFF)), $urandom, 1'b1, 80,
              1'b1, 1'b1);
    run_phase(1'b1, 11'd0, 20'd0, $urandom, 1'b1, 40, 1'b1, 1'b1);
    run_phase(1'b1, 11'd1, 20'($urandom_range(1, 20'hFFFFF)), 32'd0, 1'b1, 60,
              1'b0, 1'b0);
    run_phase(1'b0, 11'd5, 20'($urandom_range(1, 20'hFFFFF)), $urandom, 1'b0, 80,
              1'b1, 1'b1);
    run_phase(1'b1, 11'd64, 20'($urandom_range(1, 20'hFFFFF)), $urandom, 1'b1, 100,
              1'b1, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
